### rtl/core/tsgd_pkg.sv
// Shared types, constants and helpers for the simple glyph decoder.
`timescale 1ns / 1ps
package tsgd_pkg;

  localparam int MAX_POINTS_DEF   = 64;
  localparam int MAX_CONTOURS_DEF = 16;
  localparam int ADDR_W           = 6;
  localparam int FLAG_W           = 5;
  localparam int COORD_W          = 32;

  localparam int F_ON    = 0;
  localparam int F_XBYTE = 1;
  localparam int F_YBYTE = 2;
  localparam int F_XSAME = 3;
  localparam int F_YSAME = 4;

  localparam logic [3:0] HEAD_LAST = 4'd9;

  typedef enum logic [1:0] {
    KIND_POINT = 2'd0,
    KIND_NONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_HEAD,
    PH_ENDS,
    PH_ILEN,
    PH_SKIP,
    PH_FLAGS,
    PH_REP,
    PH_XLOOK,
    PH_XCHK,
    PH_XBYTE,
    PH_YLOOK,
    PH_YCHK,
    PH_YBYTE
  } phase_t;

  typedef struct packed {
    logic                flag_we;
    logic                x_we;
    logic                re;
    logic [ADDR_W-1:0]   waddr;
    logic [ADDR_W-1:0]   raddr;
    logic [FLAG_W-1:0]   flag_wdata;
    logic [COORD_W-1:0]  x_wdata;
  } store_req_t;

  typedef struct packed {
    kind_t               kind;
    logic [5:0]          point_number;
    logic [COORD_W-1:0]  x_pos;
    logic [COORD_W-1:0]  y_pos;
    logic                curve_on;
    logic                ends_contour;
    logic                last;
  } result_t;

  function automatic logic [FLAG_W-1:0] compact_flag(input logic [7:0] b);
    compact_flag = {b[5], b[4], b[2], b[1], b[0]};
  endfunction

endpackage

### rtl/core/tsgd_store.sv
// Flag and x coordinate memories, one write and one registered read a cycle.
`timescale 1ns / 1ps
module tsgd_store #(
  parameter int MAX_POINTS = tsgd_pkg::MAX_POINTS_DEF
) (
  input  logic                              clk,
  input  tsgd_pkg::store_req_t              req,
  output logic [tsgd_pkg::FLAG_W-1:0]       flag_rdata,
  output logic [tsgd_pkg::COORD_W-1:0]      x_rdata
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  logic [tsgd_pkg::FLAG_W-1:0]  flag_mem [MAX_POINTS];
  logic [tsgd_pkg::COORD_W-1:0] x_mem    [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (req.flag_we) begin
      flag_mem[req.waddr[AW-1:0]] <= req.flag_wdata;
    end
    if (req.x_we) begin
      x_mem[req.waddr[AW-1:0]] <= req.x_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      flag_rdata <= flag_mem[req.raddr[AW-1:0]];
      x_rdata    <= x_mem[req.raddr[AW-1:0]];
    end
  end

endmodule

### rtl/core/tsgd_ctrl.sv
// Record sequencer: header, contour ends, flag expansion and coordinate decode.
`timescale 1ns / 1ps
module tsgd_ctrl #(
  parameter int MAX_POINTS   = tsgd_pkg::MAX_POINTS_DEF,
  parameter int MAX_CONTOURS = tsgd_pkg::MAX_CONTOURS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              byte_valid,
  output logic                              byte_ready,
  input  logic [7:0]                        data_byte,
  input  logic                              record_start,
  input  logic                              out_free,
  output logic                              emit,
  output tsgd_pkg::result_t                 result,
  output tsgd_pkg::store_req_t              store_req,
  input  logic [tsgd_pkg::FLAG_W-1:0]       flag_rdata,
  input  logic [tsgd_pkg::COORD_W-1:0]      x_rdata
);

  localparam int PW = $clog2(MAX_POINTS + 1);
  localparam int CW = $clog2(MAX_CONTOURS + 1);
  localparam int CA = (MAX_CONTOURS > 1) ? $clog2(MAX_CONTOURS) : 1;

  tsgd_pkg::phase_t phase, phase_next, ph_eff;

  logic [3:0]                      byte_count, byte_count_next, bc_eff;
  logic [7:0]                      word_hold, word_hold_next;
  logic [15:0]                     contour_total, contour_total_next;
  logic [15:0]                     contour_ends [MAX_CONTOURS];
  logic                            ends_we;
  logic [15:0]                     ends_wdata;
  logic [PW-1:0]                   point_total, point_total_next;
  logic [15:0]                     skip_left, skip_left_next;
  logic [31:0]                     running_value, running_value_next;
  logic [PW-1:0]                   point_cursor, point_cursor_next;
  logic                            repeat_pending, repeat_pending_next;
  logic [CW-1:0]                   contour_cursor, contour_cursor_next;
  logic [7:0]                      rep_cnt, rep_cnt_next;
  logic [tsgd_pkg::FLAG_W-1:0]     last_flag, last_flag_next;

  logic          accept;
  logic [15:0]   word;
  logic          ct_none, ct_over;
  logic [PW-1:0] pc_plus, pc_inc;
  logic          pc_done, pc_room;
  logic          cc_last;
  logic          e_over;
  logic          is_x;
  logic          isb, same, coord_done;
  logic [31:0]   coord_val;
  logic          x_zero, y_zero;
  logic          rep_go;
  logic          ends_hit;

  always_comb begin
    case (phase)
      tsgd_pkg::PH_IDLE, tsgd_pkg::PH_HEAD, tsgd_pkg::PH_ENDS, tsgd_pkg::PH_ILEN,
      tsgd_pkg::PH_SKIP, tsgd_pkg::PH_FLAGS, tsgd_pkg::PH_XBYTE,
      tsgd_pkg::PH_YBYTE: byte_ready = out_free;
      default:            byte_ready = 1'b0;
    endcase
  end

  assign accept     = byte_valid && byte_ready;
  assign ph_eff     = record_start ? tsgd_pkg::PH_HEAD : phase;
  assign bc_eff     = record_start ? 4'd0 : byte_count;
  assign word       = {word_hold, data_byte};
  assign ct_none    = (contour_total == 16'd0) || contour_total[15];
  assign ct_over    = contour_total > 16'(MAX_CONTOURS);
  assign pc_plus    = point_cursor + PW'(1);
  assign pc_room    = point_cursor < point_total;
  assign pc_inc     = pc_room ? pc_plus : point_cursor;
  assign pc_done    = pc_plus >= point_total;
  assign cc_last    = (16'(contour_cursor) + 16'd1) >= contour_total;
  assign e_over     = word >= 16'(MAX_POINTS);
  assign is_x       = (phase == tsgd_pkg::PH_XBYTE);
  assign isb        = is_x ? flag_rdata[tsgd_pkg::F_XBYTE] : flag_rdata[tsgd_pkg::F_YBYTE];
  assign same       = is_x ? flag_rdata[tsgd_pkg::F_XSAME] : flag_rdata[tsgd_pkg::F_YSAME];
  assign coord_done = isb || (bc_eff != 4'd0);
  assign x_zero     = !flag_rdata[tsgd_pkg::F_XBYTE] && flag_rdata[tsgd_pkg::F_XSAME];
  assign y_zero     = !flag_rdata[tsgd_pkg::F_YBYTE] && flag_rdata[tsgd_pkg::F_YSAME];
  assign rep_go     = (rep_cnt != 8'd0) && pc_room;
  assign ends_hit   = (16'(contour_cursor) < contour_total) &&
                      (contour_ends[contour_cursor[CA-1:0]] == 16'(point_cursor));

  always_comb begin
    if (isb) begin
      coord_val = same ? running_value + {24'd0, data_byte}
                       : running_value - {24'd0, data_byte};
    end else begin
      coord_val = running_value + {{16{word[15]}}, word};
    end
  end

  always_comb begin
    phase_next = phase;
    case (phase)
      tsgd_pkg::PH_REP: begin
        if (!rep_go) begin
          phase_next = pc_room ? tsgd_pkg::PH_FLAGS : tsgd_pkg::PH_XLOOK;
        end
      end
      tsgd_pkg::PH_XLOOK: phase_next = tsgd_pkg::PH_XCHK;
      tsgd_pkg::PH_XCHK: begin
        if (x_zero) begin
          phase_next = pc_done ? tsgd_pkg::PH_YLOOK : tsgd_pkg::PH_XLOOK;
        end else begin
          phase_next = tsgd_pkg::PH_XBYTE;
        end
      end
      tsgd_pkg::PH_YLOOK: phase_next = tsgd_pkg::PH_YCHK;
      tsgd_pkg::PH_YCHK: begin
        if (!y_zero) begin
          phase_next = tsgd_pkg::PH_YBYTE;
        end else if (out_free) begin
          phase_next = pc_done ? tsgd_pkg::PH_IDLE : tsgd_pkg::PH_YLOOK;
        end
      end
      default: begin
        if (accept) begin
          case (ph_eff)
            tsgd_pkg::PH_HEAD: begin
              if (bc_eff == tsgd_pkg::HEAD_LAST) begin
                phase_next = (ct_none || ct_over) ? tsgd_pkg::PH_IDLE : tsgd_pkg::PH_ENDS;
              end else begin
                phase_next = tsgd_pkg::PH_HEAD;
              end
            end
            tsgd_pkg::PH_ENDS: begin
              if (bc_eff != 4'd0 && cc_last) begin
                phase_next = e_over ? tsgd_pkg::PH_IDLE : tsgd_pkg::PH_ILEN;
              end
            end
            tsgd_pkg::PH_ILEN: begin
              if (bc_eff != 4'd0) begin
                phase_next = (word == 16'd0) ? tsgd_pkg::PH_FLAGS : tsgd_pkg::PH_SKIP;
              end
            end
            tsgd_pkg::PH_SKIP: begin
              if (skip_left == 16'd1) begin
                phase_next = tsgd_pkg::PH_FLAGS;
              end
            end
            tsgd_pkg::PH_FLAGS: begin
              if (repeat_pending) begin
                phase_next = tsgd_pkg::PH_REP;
              end else if (!data_byte[3] && pc_inc >= point_total) begin
                phase_next = tsgd_pkg::PH_XLOOK;
              end
            end
            tsgd_pkg::PH_XBYTE: begin
              if (coord_done) begin
                phase_next = pc_done ? tsgd_pkg::PH_YLOOK : tsgd_pkg::PH_XLOOK;
              end
            end
            tsgd_pkg::PH_YBYTE: begin
              if (coord_done) begin
                phase_next = pc_done ? tsgd_pkg::PH_IDLE : tsgd_pkg::PH_YLOOK;
              end
            end
            default: phase_next = phase;
          endcase
        end
      end
    endcase
  end

  always_comb begin
    byte_count_next     = byte_count;
    word_hold_next      = word_hold;
    contour_total_next  = contour_total;
    point_total_next    = point_total;
    skip_left_next      = skip_left;
    running_value_next  = running_value;
    point_cursor_next   = point_cursor;
    repeat_pending_next = repeat_pending;
    contour_cursor_next = contour_cursor;
    rep_cnt_next        = rep_cnt;
    last_flag_next      = last_flag;
    ends_we             = 1'b0;
    ends_wdata          = word;
    emit                = 1'b0;
    result              = '0;
    result.kind         = tsgd_pkg::KIND_POINT;
    result.last         = 1'b1;
    store_req           = '0;
    store_req.waddr     = tsgd_pkg::ADDR_W'(point_cursor);
    store_req.raddr     = tsgd_pkg::ADDR_W'(point_cursor);
    store_req.flag_wdata = tsgd_pkg::compact_flag(data_byte);
    store_req.x_wdata   = coord_val;
    case (phase)
      tsgd_pkg::PH_REP: begin
        if (rep_go) begin
          store_req.flag_we    = 1'b1;
          store_req.flag_wdata = last_flag;
          point_cursor_next    = pc_plus;
          rep_cnt_next         = rep_cnt - 8'd1;
        end else if (!pc_room) begin
          point_cursor_next  = '0;
          running_value_next = '0;
          byte_count_next    = '0;
        end
      end
      tsgd_pkg::PH_XLOOK, tsgd_pkg::PH_YLOOK: store_req.re = 1'b1;
      tsgd_pkg::PH_XCHK: begin
        if (x_zero) begin
          store_req.x_we    = 1'b1;
          store_req.x_wdata = running_value;
          point_cursor_next = pc_plus;
          if (pc_done) begin
            point_cursor_next   = '0;
            contour_cursor_next = '0;
            running_value_next  = '0;
            byte_count_next     = '0;
          end
        end
      end
      tsgd_pkg::PH_YCHK: begin
        if (y_zero && out_free) begin
          emit                = 1'b1;
          result.point_number = 6'(point_cursor);
          result.x_pos        = x_rdata;
          result.y_pos        = running_value;
          result.curve_on     = flag_rdata[tsgd_pkg::F_ON];
          result.ends_contour = ends_hit;
          result.last         = pc_done;
          point_cursor_next   = pc_plus;
          if (ends_hit) begin
            contour_cursor_next = contour_cursor + CW'(1);
          end
        end
      end
      default: begin
        if (accept) begin
          case (ph_eff)
            tsgd_pkg::PH_HEAD: begin
              if (bc_eff == 4'd0) begin
                word_hold_next = data_byte;
              end
              if (bc_eff == 4'd1) begin
                contour_total_next = word;
              end
              if (bc_eff != tsgd_pkg::HEAD_LAST) begin
                byte_count_next = bc_eff + 4'd1;
              end else begin
                byte_count_next = '0;
                if (ct_none) begin
                  emit        = 1'b1;
                  result.kind = tsgd_pkg::KIND_NONE;
                end else if (ct_over) begin
                  emit        = 1'b1;
                  result.kind = tsgd_pkg::KIND_ERROR;
                end else begin
                  contour_cursor_next = '0;
                end
              end
            end
            tsgd_pkg::PH_ENDS: begin
              if (bc_eff == 4'd0) begin
                word_hold_next  = data_byte;
                byte_count_next = 4'd1;
              end else begin
                byte_count_next     = '0;
                ends_we             = (32'(contour_cursor) < MAX_CONTOURS);
                contour_cursor_next = contour_cursor + CW'(1);
                if (cc_last) begin
                  if (e_over) begin
                    emit        = 1'b1;
                    result.kind = tsgd_pkg::KIND_ERROR;
                  end else begin
                    point_total_next = PW'(word + 16'd1);
                  end
                end
              end
            end
            tsgd_pkg::PH_ILEN: begin
              if (bc_eff == 4'd0) begin
                word_hold_next  = data_byte;
                byte_count_next = 4'd1;
              end else begin
                byte_count_next     = '0;
                skip_left_next      = word;
                point_cursor_next   = '0;
                repeat_pending_next = 1'b0;
              end
            end
            tsgd_pkg::PH_SKIP: skip_left_next = skip_left - 16'd1;
            tsgd_pkg::PH_FLAGS: begin
              if (repeat_pending) begin
                repeat_pending_next = 1'b0;
                rep_cnt_next        = data_byte;
              end else begin
                if (pc_room) begin
                  store_req.flag_we = 1'b1;
                  last_flag_next    = tsgd_pkg::compact_flag(data_byte);
                end
                point_cursor_next = pc_inc;
                if (data_byte[3]) begin
                  repeat_pending_next = 1'b1;
                end else if (pc_inc >= point_total) begin
                  point_cursor_next  = '0;
                  running_value_next = '0;
                  byte_count_next    = '0;
                end
              end
            end
            tsgd_pkg::PH_XBYTE: begin
              if (!coord_done) begin
                word_hold_next  = data_byte;
                byte_count_next = 4'd1;
              end else begin
                byte_count_next    = '0;
                running_value_next = coord_val;
                store_req.x_we     = 1'b1;
                point_cursor_next  = pc_plus;
                if (pc_done) begin
                  point_cursor_next   = '0;
                  contour_cursor_next = '0;
                  running_value_next  = '0;
                end
              end
            end
            tsgd_pkg::PH_YBYTE: begin
              if (!coord_done) begin
                word_hold_next  = data_byte;
                byte_count_next = 4'd1;
              end else begin
                byte_count_next     = '0;
                running_value_next  = coord_val;
                emit                = 1'b1;
                result.point_number = 6'(point_cursor);
                result.x_pos        = x_rdata;
                result.y_pos        = coord_val;
                result.curve_on     = flag_rdata[tsgd_pkg::F_ON];
                result.ends_contour = ends_hit;
                result.last         = pc_done;
                point_cursor_next   = pc_plus;
                if (ends_hit) begin
                  contour_cursor_next = contour_cursor + CW'(1);
                end
              end
            end
            default: byte_count_next = byte_count;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= tsgd_pkg::PH_IDLE;
      byte_count     <= '0;
      word_hold      <= '0;
      contour_total  <= '0;
      point_total    <= '0;
      skip_left      <= '0;
      running_value  <= '0;
      point_cursor   <= '0;
      repeat_pending <= 1'b0;
      contour_cursor <= '0;
      rep_cnt        <= '0;
      last_flag      <= '0;
    end else begin
      phase          <= phase_next;
      byte_count     <= byte_count_next;
      word_hold      <= word_hold_next;
      contour_total  <= contour_total_next;
      point_total    <= point_total_next;
      skip_left      <= skip_left_next;
      running_value  <= running_value_next;
      point_cursor   <= point_cursor_next;
      repeat_pending <= repeat_pending_next;
      contour_cursor <= contour_cursor_next;
      rep_cnt        <= rep_cnt_next;
      last_flag      <= last_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ends_we) begin
      contour_ends[contour_cursor[CA-1:0]] <= ends_wdata;
    end
  end

endmodule

### rtl/core/truetype_simple_glyph_decoder.sv
// Top level of the simple glyph decoder: sequencer, stores and result register.
//
//   channel | valid        | ready        | payload
//   bytes   | data_valid   | data_ready   | data_byte, record_start
//   results | result_valid | result_ready | kind, point_number, x_pos, y_pos,
//           |              |              | curve_on, ends_contour, last
//
// Header, end, length, skip and flag bytes wait for a free result register.
// A repeat count fills one flag per cycle, then the sequencer leaves the fill.
// Each point of the x and y passes reads the flag/x store (registered read)
// in a look state and a check state, then takes its coordinate bytes, or none.
// Reset is synchronous and returns the sequencer to idle; no clearing pass.
// Bytes and point emits stall while the result register holds an untaken beat.
`timescale 1ns / 1ps
module truetype_simple_glyph_decoder #(
  parameter int MAX_POINTS   = tsgd_pkg::MAX_POINTS_DEF,
  parameter int MAX_CONTOURS = tsgd_pkg::MAX_CONTOURS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               data_valid,
  output logic               data_ready,
  input  logic [7:0]         data_byte,
  input  logic               record_start,
  output logic               result_valid,
  input  logic               result_ready,
  output logic [1:0]         kind,
  output logic [5:0]         point_number,
  output logic signed [31:0] x_pos,
  output logic signed [31:0] y_pos,
  output logic               curve_on,
  output logic               ends_contour,
  output logic               last
);

  tsgd_pkg::store_req_t          store_req;
  tsgd_pkg::result_t             res_in, res;
  logic [tsgd_pkg::FLAG_W-1:0]   flag_rdata;
  logic [tsgd_pkg::COORD_W-1:0]  x_rdata;
  logic                          emit;
  logic                          out_free;

  assign out_free = !result_valid || result_ready;

  tsgd_ctrl #(
    .MAX_POINTS  (MAX_POINTS),
    .MAX_CONTOURS(MAX_CONTOURS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (data_valid),
    .byte_ready  (data_ready),
    .data_byte   (data_byte),
    .record_start(record_start),
    .out_free    (out_free),
    .emit        (emit),
    .result      (res_in),
    .store_req   (store_req),
    .flag_rdata  (flag_rdata),
    .x_rdata     (x_rdata)
  );

  tsgd_store #(
    .MAX_POINTS(MAX_POINTS)
  ) u_store (
    .clk       (clk),
    .req       (store_req),
    .flag_rdata(flag_rdata),
    .x_rdata   (x_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res <= res_in;
    end
  end

  assign kind         = res.kind;
  assign point_number = res.point_number;
  assign x_pos        = res.x_pos;
  assign y_pos        = res.y_pos;
  assign curve_on     = res.curve_on;
  assign ends_contour = res.ends_contour;
  assign last         = res.last;

endmodule
